[rtl/plkt_pkg.sv]
// ============================================================================
// plkt_pkg - shared types and constants of the parent-linked key table
// Request and status codes, the command carried from the front part to the
// back part, and the packed result item.
// ============================================================================
package plkt_pkg;

    // Field widths of the stream items
    localparam int FIELD_W    = 32;
    localparam int REQ_W      = 3;
    localparam int SLOT_W     = 4;
    localparam int CFG_W      = 5;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    // Upper bound on results reported by one find-by-parent request
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Reset value of the size register
    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(16);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT      = 3'd0,
        REQ_FIND        = 3'd1,
        REQ_DELETE      = 3'd2,
        REQ_CASCADE     = 3'd3,
        REQ_FIND_PARENT = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef struct packed {
        req_t               req;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] parent;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] found_key;
        logic [FIELD_W-1:0] found_parent;
        logic               last;
    } result_t;

endpackage

[rtl/plkt_front.sv]
// ============================================================================
// plkt_front - request intake of the parent-linked key table
// Decodes the request code, drops unknown codes, trims key and parent to the
// kept width and holds the commands in a short queue for the back part.
// ============================================================================
module plkt_front #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [plkt_pkg::REQ_W-1:0]    in_req,
    input  logic [plkt_pkg::FIELD_W-1:0]  in_key,
    input  logic [plkt_pkg::FIELD_W-1:0]  in_parent,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output plkt_pkg::cmd_t                cmd
);
    import plkt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FIELD_W-1:0] KEY_MASK =
        (KEY_WIDTH >= FIELD_W) ? '1 : FIELD_W'((64'd1 << KEY_WIDTH) - 64'd1);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             known;
    logic             push;
    logic             pop;
    cmd_t             new_cmd;

    // Classify the request: codes past find-by-parent are taken and dropped
    assign known    = (in_req <= REQ_W'(REQ_FIND_PARENT));
    assign in_ready = (count_reg < CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready && known;
    assign pop      = cmd_valid && cmd_ready;

    always_comb
    begin
        new_cmd.req    = req_t'(in_req);
        new_cmd.key    = in_key & KEY_MASK;
        new_cmd.parent = in_parent & KEY_MASK;
    end

    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

[rtl/plkt_back.sv]
// ============================================================================
// plkt_back - table engine of the parent-linked key table
// Holds the key and parent memories and the occupancy bits, scans the table
// one slot per cycle unless a parent match waits on the result register,
// compacts it when an insert needs room, and drives the result register.
// ============================================================================
module plkt_back #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [plkt_pkg::CFG_W-1:0]  table_size,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  plkt_pkg::cmd_t              cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output plkt_pkg::result_t           out_res,
    output logic                        idle
);
    import plkt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT,
        S_COMPACT,
        S_PLACE
    } state_t;

    // Table storage
    logic [SW-1:0] key_mem [DEPTH];
    logic [SW-1:0] par_mem [DEPTH];
    logic [SW-1:0] rd_key_reg;
    logic [SW-1:0] rd_par_reg;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [SW-1:0] wr_key;
    logic [SW-1:0] wr_par;

    state_t                 state_reg,      state_next;
    cmd_t                   cmd_reg,        cmd_next;
    logic [CW-1:0]          size_reg,       size_next;
    logic [CW-1:0]          fill_reg,       fill_next;
    logic [CW-1:0]          used_reg,       used_next;
    logic [DEPTH-1:0]       occ_reg,        occ_next;
    logic [IW-1:0]          cur_reg,        cur_next;
    logic [IW-1:0]          wp_reg,         wp_next;
    logic                   hit_reg,        hit_next;
    logic [IW-1:0]          hit_slot_reg,   hit_slot_next;
    logic [SW-1:0]          hit_key_reg,    hit_key_next;
    logic [SW-1:0]          hit_par_reg,    hit_par_next;
    logic                   pend_reg,       pend_next;
    logic [IW-1:0]          pend_slot_reg,  pend_slot_next;
    logic [SW-1:0]          pend_key_reg,   pend_key_next;
    logic [SW-1:0]          pend_par_reg,   pend_par_next;
    logic [RES_CNT_W-1:0]   nres_reg,       nres_next;
    logic                   out_valid_reg,  out_valid_next;
    result_t                out_res_reg,    out_res_next;

    logic [CW-1:0] size_eff;
    logic [IW-1:0] last_idx;
    logic          out_free;
    logic          occ_cur;
    logic          key_hit;
    logic          child_hit;
    logic          par_hit;
    logic          at_end;
    logic          advance;
    logic          stop;
    logic          emit;
    result_t       res;
    logic [SW-1:0] req_key;
    logic [SW-1:0] req_par;

    // Clamp the configured size into 1..DEPTH
    always_comb
    begin
        if (table_size == '0)
        begin
            size_eff = CW'(1);
        end
        else if (int'(table_size) > DEPTH)
        begin
            size_eff = CW'(DEPTH);
        end
        else
        begin
            size_eff = CW'(table_size);
        end
    end

    assign last_idx  = IW'(size_reg - 1'b1);
    assign out_free  = !out_valid_reg || out_ready;
    assign req_key   = cmd_reg.key[SW-1:0];
    assign req_par   = cmd_reg.parent[SW-1:0];
    assign occ_cur   = occ_reg[cur_reg];
    assign key_hit   = occ_cur && (rd_key_reg == req_key);
    assign child_hit = occ_cur && (rd_par_reg == req_key);
    assign par_hit   = occ_cur && (rd_par_reg == req_par);
    assign at_end    = (cur_reg == last_idx);

    assign idle      = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        fill_next      = fill_reg;
        used_next      = used_reg;
        occ_next       = occ_reg;
        cur_next       = cur_reg;
        wp_next        = wp_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_key_next   = hit_key_reg;
        hit_par_next   = hit_par_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        pend_key_next  = pend_key_reg;
        pend_par_next  = pend_par_reg;
        nres_next      = nres_reg;
        cmd_ready      = 1'b0;
        emit           = 1'b0;
        res            = '0;
        wr_en          = 1'b0;
        wr_addr        = wp_reg;
        wr_key         = req_key;
        wr_par         = req_par;
        advance        = 1'b0;
        stop           = 1'b0;

        unique case (state_reg)
            // Take the next command and start the scan at slot 0
            S_IDLE:
            begin
                cur_next = '0;
                if (cmd_valid)
                begin
                    cmd_ready  = 1'b1;
                    cmd_next   = cmd;
                    size_next  = size_eff;
                    hit_next   = 1'b0;
                    used_next  = '0;
                    pend_next  = 1'b0;
                    nres_next  = '0;
                    state_next = S_SCAN;
                end
            end

            // One slot per cycle; a parent match may wait on the result register
            S_SCAN:
            begin
                advance = !(cmd_reg.req == REQ_FIND_PARENT && par_hit && pend_reg
                            && !out_free);
                if (advance)
                begin
                    stop = at_end;
                    if (key_hit && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = cur_reg;
                        hit_key_next  = rd_key_reg;
                        hit_par_next  = rd_par_reg;
                        if (cmd_reg.req == REQ_DELETE || cmd_reg.req == REQ_CASCADE)
                        begin
                            occ_next[cur_reg] = 1'b0;
                        end
                    end
                    if (cmd_reg.req == REQ_CASCADE && child_hit)
                    begin
                        occ_next[cur_reg] = 1'b0;
                    end
                    if (occ_cur)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                    if (cmd_reg.req == REQ_FIND_PARENT && par_hit)
                    begin
                        if (pend_reg)
                        begin
                            emit             = 1'b1;
                            res.status       = ST_OK;
                            res.slot         = SLOT_W'(pend_slot_reg);
                            res.found_key    = FIELD_W'(pend_key_reg);
                            res.found_parent = FIELD_W'(pend_par_reg);
                            res.last         = 1'b0;
                        end
                        pend_next      = 1'b1;
                        pend_slot_next = cur_reg;
                        pend_key_next  = rd_key_reg;
                        pend_par_next  = rd_par_reg;
                        nres_next      = nres_reg + 1'b1;
                        if (nres_reg == RES_CNT_W'(MAX_RESULTS - 1))
                        begin
                            stop = 1'b1;
                        end
                    end
                    if (stop)
                    begin
                        cur_next   = '0;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
            end

            // Deliver the closing result, or start a compaction pass
            S_RESULT:
            begin
                cur_next = '0;
                if (out_free)
                begin
                    state_next = S_IDLE;
                    res.last   = 1'b1;
                    unique case (cmd_reg.req)
                        REQ_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                emit             = 1'b1;
                                res.status       = ST_DUP;
                                res.slot         = SLOT_W'(hit_slot_reg);
                                res.found_key    = FIELD_W'(hit_key_reg);
                                res.found_parent = FIELD_W'(hit_par_reg);
                            end
                            else if (fill_reg < size_reg)
                            begin
                                emit                          = 1'b1;
                                wr_en                         = 1'b1;
                                wr_addr                       = fill_reg[IW-1:0];
                                occ_next[fill_reg[IW-1:0]]    = (req_par != '0);
                                fill_next                     = fill_reg + 1'b1;
                                res.status                    = ST_OK;
                                res.slot                      = SLOT_W'(fill_reg[IW-1:0]);
                                res.found_key                 = cmd_reg.key;
                                res.found_parent              = cmd_reg.parent;
                            end
                            else if (used_reg == size_reg)
                            begin
                                emit             = 1'b1;
                                res.status       = ST_FULL;
                                res.slot         = '0;
                                res.found_key    = cmd_reg.key;
                                res.found_parent = cmd_reg.parent;
                            end
                            else
                            begin
                                wp_next    = '0;
                                state_next = S_COMPACT;
                            end
                        end
                        REQ_FIND, REQ_DELETE, REQ_CASCADE:
                        begin
                            emit = 1'b1;
                            if (hit_reg)
                            begin
                                res.status       = ST_OK;
                                res.slot         = SLOT_W'(hit_slot_reg);
                                res.found_key    = FIELD_W'(hit_key_reg);
                                res.found_parent = FIELD_W'(hit_par_reg);
                            end
                            else
                            begin
                                res.status       = ST_MISS;
                                res.slot         = '0;
                                res.found_key    = cmd_reg.key;
                                res.found_parent = '0;
                            end
                        end
                        REQ_FIND_PARENT:
                        begin
                            emit = 1'b1;
                            if (pend_reg)
                            begin
                                res.status       = ST_OK;
                                res.slot         = SLOT_W'(pend_slot_reg);
                                res.found_key    = FIELD_W'(pend_key_reg);
                                res.found_parent = FIELD_W'(pend_par_reg);
                            end
                            else
                            begin
                                res.status       = ST_MISS;
                                res.slot         = '0;
                                res.found_key    = '0;
                                res.found_parent = cmd_reg.parent;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end

            // Move occupied slots to the front, keeping their order
            S_COMPACT:
            begin
                if (occ_cur)
                begin
                    if (wp_reg != cur_reg)
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = wp_reg;
                        wr_key            = rd_key_reg;
                        wr_par            = rd_par_reg;
                        occ_next[wp_reg]  = 1'b1;
                        occ_next[cur_reg] = 1'b0;
                    end
                    wp_next = wp_reg + 1'b1;
                end
                if (at_end)
                begin
                    cur_next   = '0;
                    state_next = S_PLACE;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end

            // Write the new entry at the first free slot
            S_PLACE:
            begin
                cur_next = '0;
                if (out_free)
                begin
                    wr_en            = 1'b1;
                    wr_addr          = wp_reg;
                    occ_next[wp_reg] = (req_par != '0);
                    emit             = 1'b1;
                    res.status       = ST_OK;
                    res.slot         = SLOT_W'(wp_reg);
                    res.found_key    = cmd_reg.key;
                    res.found_parent = cmd_reg.parent;
                    res.last         = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Result register: load on emit, drop once taken
        out_res_next = out_res_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            hit_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            nres_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            hit_reg       <= hit_next;
            pend_reg      <= pend_next;
            nres_reg      <= nres_next;
            cmd_reg       <= cmd_next;
            size_reg      <= size_next;
            used_reg      <= used_next;
            wp_reg        <= wp_next;
            hit_slot_reg  <= hit_slot_next;
            hit_key_reg   <= hit_key_next;
            hit_par_reg   <= hit_par_next;
            pend_slot_reg <= pend_slot_next;
            pend_key_reg  <= pend_key_next;
            pend_par_reg  <= pend_par_next;
            out_res_reg   <= out_res_next;
        end
    end

    // Table memory: one write port, one registered read at the next slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            par_mem[wr_addr] <= wr_par;
        end
        rd_key_reg <= key_mem[cur_next];
        rd_par_reg <= par_mem[cur_next];
    end

endmodule

[rtl/parent_linked_key_table.sv]
// ============================================================================
// parent_linked_key_table - table of key and parent-key pairs
// Insert, find by key, delete, cascade delete and find by parent over a small
// table in which a zero parent marks a slot free.
// ============================================================================
//
//  channel     | direction | fields (lowest bit first)
//  ------------+-----------+---------------------------------------------------
//  cfg         | in        | cfg_wdata = table_size
//  s_axis      | in        | tuser = req_type; tdata = key, parent
//  m_axis      | out       | tdata = status, slot, found_key, found_parent, 0;
//              |           | tlast = last
//
//  A request passes through the table engine as a pop state, a scan of the
//  slots through the single memory read port and a result state; an insert
//  that must compact the table adds a compaction pass and a place state.
//  The two-entry command queue takes new requests while the engine works.
//  Reset clears the occupancy bits and fill count; no clearing pass is needed.
//  A stalled result register holds the engine in the result and place cycles,
//  and at a find-by-parent match while an earlier match still waits.
//
module parent_linked_key_table #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [plkt_pkg::CFG_W-1:0]       cfg_wdata,       // table_size
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [plkt_pkg::IN_DATA_W-1:0]   s_axis_tdata,    // key, parent
    input  logic [plkt_pkg::REQ_W-1:0]       s_axis_tuser,    // req_type
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [plkt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,    // status, slot,
                                                              // found_key, found_parent
    output logic                             m_axis_tlast
);
    import plkt_pkg::*;

    logic [CFG_W-1:0] table_size_reg;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_t             cmd;
    result_t          res;
    logic             back_idle;

    // Hold the size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            table_size_reg <= cfg_wdata;
        end
    end

    plkt_front #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (s_axis_tuser),
        .in_key    (s_axis_tdata[FIELD_W-1:0]),
        .in_parent (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    plkt_back #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .table_size (table_size_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res),
        .idle       (back_idle)
    );

    // Pack the result item
    assign m_axis_tdata = {2'b00, res.found_parent, res.found_key, res.slot, res.status};
    assign m_axis_tlast = res.last;

    // A new result only appears after the engine has been working
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!back_idle))
        else $error("result appeared while the engine was idle");

    // A miss always closes its request
    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ST_MISS) |-> m_axis_tlast)
        else $error("miss result without last");

    // Duplicate and full results are single and report slot 0 when full
    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ST_DUP || m_axis_tdata[1:0] == ST_FULL)
        |-> m_axis_tlast)
        else $error("insert rejection without last");

    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL) |-> (m_axis_tdata[5:2] == '0))
        else $error("full result with nonzero slot");

endmodule
